@@ design/cct_pkg.sv @@
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types and codes for the character class tokenizer: request and
// response payloads, character classes, run states and result bundles.
// ----------------------------------------------------------------------------
package cct_pkg;

   localparam int MAX_RESULTS = 3;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic [1:0] KIND_REGULAR = 2'd0;
   localparam logic [1:0] KIND_DELIM   = 2'd1;
   localparam logic [1:0] KIND_MARKER  = 2'd2;

   typedef enum logic [1:0] {
      CT_REGULAR = 2'd0,
      CT_DELIM   = 2'd1,
      CT_SPACE   = 2'd2,
      CT_UNITE   = 2'd3
   } char_class_type;

   typedef enum logic [1:0] {
      RUN_NONE    = 2'd0,
      RUN_REGULAR = 2'd1,
      RUN_DELIM   = 2'd2
   } run_type;

   typedef struct packed {
      logic        opcode;
      logic [15:0] char_code;
      logic [1:0]  char_type;
      logic        end_of_string;
   } req_type;

   typedef struct packed {
      logic [15:0] term_char;
      logic [1:0]  term_kind;
      logic [15:0] word_offset;
      logic        term_last;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        rd_en;
      logic        wr_en;
      logic [15:0] code;
      logic [1:0]  ctype;
   } tbl_req_type;

   typedef struct packed {
      rsp_type [MAX_RESULTS-1:0] res;
      logic [1:0]                count;
   } bundle_type;

endpackage

@@ design/cct_type_mem.sv @@
// ----------------------------------------------------------------------------
// cct_type_mem
// Character class table: one synchronous memory with a registered read,
// cleared to the regular class by a sweep after reset.
// ----------------------------------------------------------------------------
module cct_type_mem #(
   parameter int TABLE_DEPTH = 65536
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cct_pkg::tbl_req_type    tbl_req,
   output cct_pkg::char_class_type rd_type,
   output logic                    busy
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   logic [1:0]       mem [TABLE_DEPTH];
   logic             clr_ff, clr_in;
   logic [IDX_W-1:0] clr_addr_ff, clr_addr_in;
   logic [1:0]       rd_ff;
   logic             oor_ff;
   logic             in_range;
   logic [IDX_W-1:0] idx;

   assign in_range = (32'(tbl_req.code) < 32'(TABLE_DEPTH));
   assign idx      = tbl_req.code[IDX_W-1:0];
   assign busy     = clr_ff;
   assign rd_type  = oor_ff ? cct_pkg::CT_REGULAR : cct_pkg::char_class_type'(rd_ff);

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         if (clr_addr_ff == LAST_IDX) begin
            clr_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_addr_ff] <= 2'(cct_pkg::CT_REGULAR);
      end else if (tbl_req.wr_en && in_range) begin
         mem[idx] <= tbl_req.ctype;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_req.rd_en) begin
         rd_ff  <= mem[idx];
         oor_ff <= !in_range;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !(tbl_req.rd_en || tbl_req.wr_en))
      else $error("table access during clear sweep");

endmodule

@@ design/cct_engine.sv @@
// ----------------------------------------------------------------------------
// cct_engine
// Term tracking: takes the looked-up class of each character, updates the
// held character, run state and word count, and builds the result bundle.
// ----------------------------------------------------------------------------
module cct_engine #(
   parameter int OFFSET_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    mode,
   input  logic                    char_accept,
   input  logic [15:0]             char_code,
   input  logic                    end_of_string,
   input  cct_pkg::char_class_type tbl_type,
   input  logic                    out_free,
   output logic                    push,
   output cct_pkg::bundle_type     bundle,
   output logic                    stall
);

   logic                   s1_valid_ff, s1_valid_in;
   logic [15:0]            s1_char_ff, s1_char_in;
   logic                   s1_eos_ff, s1_eos_in;

   logic [15:0]            held_char_ff, held_char_in;
   logic                   held_valid_ff, held_valid_in;
   logic                   held_kind_ff, held_kind_in;
   cct_pkg::run_type       run_ff, run_in;
   logic [OFFSET_BITS-1:0] count_ff, count_in;
   logic                   pwd_ff, pwd_in;

   logic                   advance;
   logic                   do_close;
   logic                   do_hold;
   logic                   hold_kind;
   cct_pkg::run_type       run_next;
   logic [1:0]             n;

   assign advance = s1_valid_ff && ((bundle.count == 2'd0) || out_free);
   assign push    = advance && (bundle.count != 2'd0);
   assign stall   = s1_valid_ff && !advance;

   always_comb begin
      do_close  = 1'b0;
      do_hold   = 1'b0;
      hold_kind = 1'b0;
      run_next  = cct_pkg::RUN_NONE;
      unique case (tbl_type)
         cct_pkg::CT_REGULAR, cct_pkg::CT_UNITE: begin
            do_close = (run_ff != cct_pkg::RUN_REGULAR);
            do_hold  = (tbl_type == cct_pkg::CT_REGULAR);
            run_next = cct_pkg::RUN_REGULAR;
         end
         cct_pkg::CT_SPACE: begin
            do_close = 1'b1;
         end
         cct_pkg::CT_DELIM: begin
            do_close  = mode || (run_ff != cct_pkg::RUN_DELIM);
            do_hold   = !mode;
            hold_kind = 1'b1;
            run_next  = mode ? cct_pkg::RUN_NONE : cct_pkg::RUN_DELIM;
         end
      endcase
   end

   always_comb begin
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      held_kind_in  = held_kind_ff;
      count_in      = count_ff;
      pwd_in        = pwd_ff;
      bundle        = '0;
      n             = 2'd0;

      if (mode) begin
         if (pwd_in && (tbl_type != cct_pkg::CT_DELIM) && (count_in != '1)) begin
            count_in = count_in + OFFSET_BITS'(1);
         end
         pwd_in = (tbl_type == cct_pkg::CT_DELIM);
      end else begin
         pwd_in = 1'b0;
      end

      if (do_close) begin
         if (held_valid_in) begin
            bundle.res[n].term_char   = held_char_in;
            bundle.res[n].term_kind   = {1'b0, held_kind_in};
            bundle.res[n].word_offset = 16'(32'(count_in));
            bundle.res[n].term_last   = 1'b1;
            n = n + 2'd1;
            if (count_in != '1) begin
               count_in = count_in + OFFSET_BITS'(1);
            end
         end
         held_valid_in = 1'b0;
      end

      if (do_hold) begin
         if (held_valid_in) begin
            bundle.res[n].term_char   = held_char_in;
            bundle.res[n].term_kind   = {1'b0, held_kind_in};
            bundle.res[n].word_offset = 16'(32'(count_in));
            bundle.res[n].term_last   = 1'b0;
            n = n + 2'd1;
         end
         held_char_in  = s1_char_ff;
         held_kind_in  = hold_kind;
         held_valid_in = 1'b1;
      end

      run_in = run_next;

      if (s1_eos_ff) begin
         if (held_valid_in) begin
            bundle.res[n].term_char   = held_char_in;
            bundle.res[n].term_kind   = {1'b0, held_kind_in};
            bundle.res[n].word_offset = 16'(32'(count_in));
            bundle.res[n].term_last   = 1'b1;
            n = n + 2'd1;
            if (count_in != '1) begin
               count_in = count_in + OFFSET_BITS'(1);
            end
         end
         bundle.res[n].term_char   = 16'd0;
         bundle.res[n].term_kind   = cct_pkg::KIND_MARKER;
         bundle.res[n].word_offset = 16'(32'(count_in));
         bundle.res[n].term_last   = 1'b0;
         n = n + 2'd1;
         held_char_in  = 16'd0;
         held_valid_in = 1'b0;
         held_kind_in  = 1'b0;
         run_in        = cct_pkg::RUN_NONE;
         count_in      = '0;
         pwd_in        = 1'b0;
      end

      if (n != 2'd0) begin
         bundle.res[n - 2'd1].last = 1'b1;
      end
      bundle.count = n;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff && !advance;
      s1_char_in  = s1_char_ff;
      s1_eos_in   = s1_eos_ff;
      if (char_accept) begin
         s1_valid_in = 1'b1;
         s1_char_in  = char_code;
         s1_eos_in   = end_of_string;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_char_ff <= s1_char_in;
      s1_eos_ff  <= s1_eos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_char_ff  <= 16'd0;
         held_valid_ff <= 1'b0;
         held_kind_ff  <= 1'b0;
         run_ff        <= cct_pkg::RUN_NONE;
         count_ff      <= '0;
         pwd_ff        <= 1'b0;
      end else if (advance) begin
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
         held_kind_ff  <= held_kind_in;
         run_ff        <= run_in;
         count_ff      <= count_in;
         pwd_ff        <= pwd_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (advance && s1_eos_ff) |=> (!held_valid_ff && (count_ff == '0)
                                  && (run_ff == cct_pkg::RUN_NONE)))
      else $error("stream state not cleared at end of string");

   assert property (@(posedge clock) disable iff (reset)
      char_accept |-> !stall)
      else $error("request taken while engine stage blocked");

endmodule

@@ design/cct_out_queue.sv @@
// ----------------------------------------------------------------------------
// cct_out_queue
// Result bundle register: holds the results of one request and sends them
// one per cycle on the response channel while rsp_stall is low.
// ----------------------------------------------------------------------------
module cct_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cct_pkg::bundle_type bundle,
   output logic                out_free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cct_pkg::rsp_type    rsp_payload
);

   cct_pkg::bundle_type bun_ff, bun_in;
   logic                send;

   assign rsp_valid   = (bun_ff.count != 2'd0);
   assign rsp_payload = bun_ff.res[0];
   assign send        = rsp_valid && !rsp_stall;
   assign out_free    = (bun_ff.count == 2'd0) || ((bun_ff.count == 2'd1) && send);

   always_comb begin
      bun_in = bun_ff;
      if (push) begin
         bun_in = bundle;
      end else if (send) begin
         bun_in.res[0] = bun_ff.res[1];
         bun_in.res[1] = bun_ff.res[2];
         bun_in.res[2] = '0;
         bun_in.count  = bun_ff.count - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bun_ff.count <= 2'd0;
      end else begin
         bun_ff.count <= bun_in.count;
      end
      bun_ff.res <= bun_in.res;
   end

   assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("bundle pushed while results still pending");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (bun_ff.res[0].last == (bun_ff.count == 2'd1)))
      else $error("last flag out of step with pending count");

endmodule

@@ design/char_class_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// char_class_tokenizer_core
// Requests are captured into the engine stage and the table read register;
// their results are then registered in the result bundle register.
// Throughput: one request per cycle while req_stall is low; a request with
// several results stalls the input while the result register drains.
// Reset: sweeps the class table to regular with req_stall high; csr writes
// are taken during the sweep.
// ----------------------------------------------------------------------------
module char_class_tokenizer_core #(
   parameter int TABLE_DEPTH = 65536,
   parameter int OFFSET_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cct_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cct_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);

   logic                    mode_ff, mode_in;
   logic                    req_accept;
   logic                    char_accept;
   logic                    tbl_busy;
   logic                    eng_stall;
   logic                    out_free;
   logic                    push;
   cct_pkg::tbl_req_type    tbl_req;
   cct_pkg::char_class_type rd_type;
   cct_pkg::bundle_type     bundle;

   assign csr_ready   = 1'b1;
   assign req_stall   = tbl_busy || eng_stall;
   assign req_accept  = req_valid && !req_stall;
   assign char_accept = req_accept && (req_payload.opcode == cct_pkg::OP_CHAR);

   assign tbl_req.rd_en = char_accept;
   assign tbl_req.wr_en = req_accept && (req_payload.opcode == cct_pkg::OP_LOAD);
   assign tbl_req.code  = req_payload.char_code;
   assign tbl_req.ctype = req_payload.char_type;

   assign mode_in = (csr_valid && csr_ready) ? csr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   cct_type_mem #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_type_mem (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .rd_type (rd_type),
      .busy    (tbl_busy)
   );

   cct_engine #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .mode          (mode_ff),
      .char_accept   (char_accept),
      .char_code     (req_payload.char_code),
      .end_of_string (req_payload.end_of_string),
      .tbl_type      (rd_type),
      .out_free      (out_free),
      .push          (push),
      .bundle        (bundle),
      .stall         (eng_stall)
   );

   cct_out_queue u_out_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .bundle      (bundle),
      .out_free    (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
